// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the resampler RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GDSR_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define GDSR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GDSR_ASSERT_IMPLY(lbl, ante, cons, msg)
`define GDSR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/gdsr_pkg.sv -----
// Types, constants and codes of the granular dual-sample resampler.
// No dependencies.
package gdsr_pkg;

   localparam int SAMPLE_DEPTH_DEF = 4096;
   localparam int GRAINS_DEF       = 8;

   localparam int KIND_W      = 3;
   localparam int ADDR_IN_W   = 12;
   localparam int SAMPLE_W    = 16;
   localparam int GIDX_IN_W   = 3;
   localparam int PHASE_IN_W  = 29;
   localparam int FRAC_W      = 16;
   localparam int LEN_W       = 13;
   localparam int STEP_W      = 24;
   localparam int WEIGHT_W    = 17;
   localparam int GAIN_W      = 16;
   localparam int GIU_W       = 4;
   localparam int GCNT_W      = 7;
   localparam int DIVD_W      = 15;
   localparam int DIVS_W      = 14;
   localparam int PH_W        = DIVS_W + FRAC_W;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK        = 3'd0,
      KIND_WRITE_LOW   = 3'd1,
      KIND_WRITE_HIGH  = 3'd2,
      KIND_PHASE_LOW   = 3'd3,
      KIND_PHASE_HIGH  = 3'd4
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LENGTH_LOW    = 3'd0,
      CSR_LENGTH_HIGH   = 3'd1,
      CSR_STEP_LOW      = 3'd2,
      CSR_STEP_HIGH     = 3'd3,
      CSR_MIX_WEIGHT    = 3'd4,
      CSR_GAIN          = 3'd5,
      CSR_GRAINS_IN_USE = 3'd6,
      CSR_PING_PONG     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [KIND_W-1:0]          kind;
      logic [ADDR_IN_W-1:0]       word_address;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic [GIDX_IN_W-1:0]       grain_index;
      logic [PHASE_IN_W-1:0]      phase_value;
   } item_type;

   typedef struct packed {
      logic [LEN_W-1:0]    len_lo;
      logic [LEN_W-1:0]    len_hi;
      logic [STEP_W-1:0]   step_lo;
      logic [STEP_W-1:0]   step_hi;
      logic [WEIGHT_W-1:0] weight;
      logic [GAIN_W-1:0]   gain;
      logic [GCNT_W-1:0]   grain_count;
      logic                ping_pong;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVS_W-1:0] remainder;
   } rem_rsp_type;

endpackage

// ----- rtl/gdsr_if.sv -----
// Channel interfaces of the resampler: request items and result items.
// Depends on gdsr_pkg.
interface gdsr_req_if;
   import gdsr_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          kind;
   logic [ADDR_IN_W-1:0]       word_address;
   logic signed [SAMPLE_W-1:0] sample_value;
   logic [GIDX_IN_W-1:0]       grain_index;
   logic [PHASE_IN_W-1:0]      phase_value;
   modport source (output valid, kind, word_address, sample_value, grain_index,
                   phase_value, input ready);
   modport sink (input valid, kind, word_address, sample_value, grain_index,
                 phase_value, output ready);
endinterface

interface gdsr_rsp_if;
   import gdsr_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] mixed_sample;
   modport source (output valid, mixed_sample, input ready);
   modport sink (input valid, mixed_sample, output ready);
endinterface

// ----- rtl/gdsr_rem_unit.sv -----
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// Depends on gdsr_pkg.
module gdsr_rem_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  gdsr_pkg::rem_req_type req,
   output gdsr_pkg::rem_rsp_type rsp
);
   import gdsr_pkg::*;

   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DIVD_W-1:0] dvd_ff;
   logic [DIVS_W-1:0] dvs_ff;
   logic [DIVS_W-1:0] rem_ff;
   logic [DIVS_W:0]   trial;
   logic [DIVS_W:0]   trial_sub;

   assign trial     = {rem_ff, dvd_ff[DIVD_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVD_W);
            dvd_ff  <= req.dividend;
            dvs_ff  <= req.divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            // keep the partial remainder below the divisor
            rem_ff <= (trial >= {1'b0, dvs_ff}) ? DIVS_W'(trial_sub) : DIVS_W'(trial);
            dvd_ff <= dvd_ff << 1;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ----- rtl/gdsr_engine.sv -----
// Grain sequencer: sample and phase memories, interpolation, crossfade, sum.
// Depends on gdsr_pkg, assert_macros.svh; drives the shared remainder unit.
module gdsr_engine #(
   parameter int SAMPLE_DEPTH = gdsr_pkg::SAMPLE_DEPTH_DEF,
   parameter int GRAINS       = gdsr_pkg::GRAINS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  gdsr_pkg::item_type            item,
   input  gdsr_pkg::cfg_type             cfg,
   input  logic                          out_free,
   output logic                          idle,
   output logic                          res_valid,
   output logic signed [gdsr_pkg::SAMPLE_W-1:0] res_sample,
   output gdsr_pkg::rem_req_type         rem_req,
   input  gdsr_pkg::rem_rsp_type         rem_rsp
);
   import gdsr_pkg::*;
   `include "assert_macros.svh"

   localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
   localparam int GIDX_W = (GRAINS > 1) ? $clog2(GRAINS) : 1;
   localparam int V_W    = 32;
   localparam int MA_W   = 33;
   localparam int MB_W   = 18;
   localparam int P_W    = MA_W + MB_W;
   localparam int T_W    = 50;
   localparam int ACC_W  = 56;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD_WAIT, ST_PH_RD, ST_PH_WAIT, ST_DIV_START, ST_DIV_WAIT,
      ST_RD1, ST_RD2, ST_CAPT, ST_M1, ST_M2, ST_M3, ST_ADV_WAIT,
      ST_MIX1, ST_MIX2, ST_MIX3, ST_MIX4, ST_MIX5, ST_FIN
   } state_type;

   state_type                  state_ff;
   logic [GIDX_W-1:0]          g_ff;
   logic                       side_ff;
   logic                       load_side_ff;
   logic [GIDX_W-1:0]          load_g_ff;
   logic [FRAC_W-1:0]          load_frac_ff;
   logic [FRAC_W-1:0]          adv_frac_ff;
   logic [PH_W-1:0]            cur_lo_ff;
   logic [PH_W-1:0]            cur_hi_ff;
   logic [DIVS_W-1:0]          rem_ff;
   logic signed [SAMPLE_W-1:0] s1_ff;
   logic signed [SAMPLE_W-1:0] s2_ff;
   logic signed [V_W-1:0]      v_ff;
   logic signed [V_W-1:0]      vl_ff;
   logic signed [V_W-1:0]      vh_ff;
   logic signed [T_W-1:0]      t_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [P_W-1:0]      prod_ff;
   logic                       res_valid_ff;
   logic signed [SAMPLE_W-1:0] res_ff;

   // memories
   logic signed [SAMPLE_W-1:0] mem_lo [SAMPLE_DEPTH];
   logic signed [SAMPLE_W-1:0] mem_hi [SAMPLE_DEPTH];
   logic signed [SAMPLE_W-1:0] mem_lo_rd_ff;
   logic signed [SAMPLE_W-1:0] mem_hi_rd_ff;
   logic [PH_W-1:0]            ph_lo_mem [GRAINS];
   logic [PH_W-1:0]            ph_hi_mem [GRAINS];
   logic [PH_W-1:0]            ph_lo_rd_ff;
   logic [PH_W-1:0]            ph_hi_rd_ff;
   logic [GRAINS-1:0]          vld_lo_ff;
   logic [GRAINS-1:0]          vld_hi_ff;

   // datapath
   logic [PH_W-1:0]            cur_p;
   logic [LEN_W-1:0]           cur_len;
   logic [DIVS_W-1:0]          cur_two_len;
   logic [STEP_W-1:0]          cur_step;
   logic [FRAC_W:0]            cur_f;
   logic [DIVS_W-1:0]          rem_next;
   logic [LEN_W-1:0]           idx1;
   logic [LEN_W-1:0]           idx2;
   logic [LEN_W-1:0]           rd_index;
   logic [ADDR_W-1:0]          rd_addr;
   logic signed [SAMPLE_W-1:0] rd_data;
   logic [PH_W:0]              psum;
   logic signed [MA_W-1:0]     mul_a;
   logic signed [MB_W-1:0]     mul_b;
   logic signed [ACC_W-1:0]    acc_rnd;
   logic signed [ACC_W-29:0]   acc_top;
   logic                       item_load;
   logic                       item_high;
   logic                       ph_we_lo;
   logic                       ph_we_hi;
   logic [GIDX_W-1:0]          ph_waddr;
   logic [PH_W-1:0]            ph_wdata;

   function automatic logic [LEN_W-1:0] fold_index(input logic [DIVS_W-1:0] r2l,
                                                   input logic [LEN_W-1:0] len,
                                                   input logic pp);
      logic              odd;
      logic [DIVS_W-1:0] r;
      odd = (r2l >= {1'b0, len});
      r   = odd ? r2l - {1'b0, len} : r2l;
      if (pp && odd) begin
         return LEN_W'({1'b0, len} - DIVS_W'(1) - r);
      end
      return LEN_W'(r);
   endfunction

   assign cur_p       = side_ff ? cur_hi_ff : cur_lo_ff;
   assign cur_len     = side_ff ? cfg.len_hi : cfg.len_lo;
   assign cur_two_len = {cur_len, 1'b0};
   assign cur_step    = side_ff ? cfg.step_hi : cfg.step_lo;
   assign cur_f       = {1'b0, cur_p[FRAC_W-1:0]};
   assign rem_next    = (rem_ff + DIVS_W'(1) == cur_two_len) ? '0 : rem_ff + DIVS_W'(1);
   assign idx1        = fold_index(rem_ff, cur_len, cfg.ping_pong);
   assign idx2        = fold_index(rem_next, cur_len, cfg.ping_pong);
   assign rd_index    = (state_ff == ST_RD1) ? idx1 : idx2;
   assign rd_addr     = ADDR_W'(rd_index);
   assign rd_data     = side_ff ? mem_hi_rd_ff : mem_lo_rd_ff;
   assign psum        = (PH_W + 1)'(cur_p) + (PH_W + 1)'(cur_step);

   assign item_load = item_valid && (state_ff == ST_IDLE) &&
                      ((item.kind == KIND_PHASE_LOW) || (item.kind == KIND_PHASE_HIGH)) &&
                      (32'(item.grain_index) < GRAINS);
   assign item_high = (item.kind == KIND_PHASE_HIGH);

   // remainder requests: phase load, read index, advance
   always_comb begin
      rem_req.start    = item_load || (state_ff == ST_DIV_START) || (state_ff == ST_CAPT);
      rem_req.dividend = {1'b0, cur_p[PH_W-1:FRAC_W]};
      rem_req.divisor  = cur_two_len;
      case (state_ff)
         ST_IDLE: begin
            rem_req.dividend = DIVD_W'(item.phase_value[PHASE_IN_W-1:FRAC_W]);
            rem_req.divisor  = item_high ? {cfg.len_hi, 1'b0} : {cfg.len_lo, 1'b0};
         end
         ST_CAPT: begin
            rem_req.dividend = psum[PH_W:FRAC_W];
         end
         default: begin
         end
      endcase
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_M1: begin
            mul_a = MA_W'(s1_ff);
            mul_b = $signed({1'b0, (FRAC_W + 1)'(WEIGHT_ONE) - cur_f});
         end
         ST_M2: begin
            mul_a = MA_W'(s2_ff);
            mul_b = $signed({1'b0, cur_f});
         end
         ST_MIX1: begin
            mul_a = MA_W'(vl_ff);
            mul_b = $signed({1'b0, WEIGHT_ONE - cfg.weight});
         end
         ST_MIX2: begin
            mul_a = MA_W'(vh_ff);
            mul_b = $signed({1'b0, cfg.weight});
         end
         ST_MIX4: begin
            mul_a = t_ff[48:16];
            mul_b = $signed({2'b00, cfg.gain});
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // sample memories: written by items, read one word a cycle
   always_ff @(posedge clock) begin
      if (item_valid && (state_ff == ST_IDLE) && (32'(item.word_address) < SAMPLE_DEPTH)) begin
         if (item.kind == KIND_WRITE_LOW) begin
            mem_lo[ADDR_W'(item.word_address)] <= item.sample_value;
         end
         if (item.kind == KIND_WRITE_HIGH) begin
            mem_hi[ADDR_W'(item.word_address)] <= item.sample_value;
         end
      end
      mem_lo_rd_ff <= mem_lo[rd_addr];
      mem_hi_rd_ff <= mem_hi[rd_addr];
   end

   // phase memories with per-grain valid bits (unwritten reads as zero)
   assign ph_we_lo = rem_rsp.done &&
                     (((state_ff == ST_LOAD_WAIT) && !load_side_ff) ||
                      ((state_ff == ST_ADV_WAIT) && !side_ff));
   assign ph_we_hi = rem_rsp.done &&
                     (((state_ff == ST_LOAD_WAIT) && load_side_ff) ||
                      ((state_ff == ST_ADV_WAIT) && side_ff));
   assign ph_waddr = (state_ff == ST_LOAD_WAIT) ? load_g_ff : g_ff;
   assign ph_wdata = {rem_rsp.remainder,
                      (state_ff == ST_LOAD_WAIT) ? load_frac_ff : adv_frac_ff};

   always_ff @(posedge clock) begin
      if (ph_we_lo) begin
         ph_lo_mem[ph_waddr] <= ph_wdata;
      end
      if (ph_we_hi) begin
         ph_hi_mem[ph_waddr] <= ph_wdata;
      end
      ph_lo_rd_ff <= ph_lo_mem[g_ff];
      ph_hi_rd_ff <= ph_hi_mem[g_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_lo_ff <= '0;
         vld_hi_ff <= '0;
      end else begin
         if (ph_we_lo) begin
            vld_lo_ff[ph_waddr] <= 1'b1;
         end
         if (ph_we_hi) begin
            vld_hi_ff[ph_waddr] <= 1'b1;
         end
      end
   end

   // round and saturate the grain sum
   assign acc_rnd = acc_ff + ACC_W'(64'sd134217728);
   assign acc_top = acc_rnd[ACC_W-1:28];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  case (item.kind)
                     KIND_TICK: begin
                        acc_ff <= '0;
                        g_ff   <= '0;
                        state_ff <= (cfg.grain_count == '0) ? ST_FIN : ST_PH_RD;
                     end
                     KIND_PHASE_LOW, KIND_PHASE_HIGH: begin
                        if (item_load) begin
                           load_side_ff <= item_high;
                           load_g_ff    <= GIDX_W'(item.grain_index);
                           load_frac_ff <= item.phase_value[FRAC_W-1:0];
                           state_ff     <= ST_LOAD_WAIT;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_LOAD_WAIT: begin
               if (rem_rsp.done) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_PH_RD: begin
               state_ff <= ST_PH_WAIT;
            end
            ST_PH_WAIT: begin
               cur_lo_ff <= vld_lo_ff[g_ff] ? ph_lo_rd_ff : '0;
               cur_hi_ff <= vld_hi_ff[g_ff] ? ph_hi_rd_ff : '0;
               side_ff   <= 1'b0;
               state_ff  <= ST_DIV_START;
            end
            ST_DIV_START: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (rem_rsp.done) begin
                  rem_ff   <= rem_rsp.remainder;
                  state_ff <= ST_RD1;
               end
            end
            ST_RD1: begin
               state_ff <= ST_RD2;
            end
            ST_RD2: begin
               s1_ff    <= rd_data;
               state_ff <= ST_CAPT;
            end
            ST_CAPT: begin
               s2_ff       <= rd_data;
               adv_frac_ff <= psum[FRAC_W-1:0];
               state_ff    <= ST_M1;
            end
            ST_M1: begin
               state_ff <= ST_M2;
            end
            ST_M2: begin
               v_ff     <= V_W'(prod_ff);
               state_ff <= ST_M3;
            end
            ST_M3: begin
               if (side_ff) begin
                  vh_ff <= V_W'(P_W'(v_ff) + prod_ff);
               end else begin
                  vl_ff <= V_W'(P_W'(v_ff) + prod_ff);
               end
               state_ff <= ST_ADV_WAIT;
            end
            ST_ADV_WAIT: begin
               if (rem_rsp.done) begin
                  if (side_ff) begin
                     state_ff <= ST_MIX1;
                  end else begin
                     side_ff  <= 1'b1;
                     state_ff <= ST_DIV_START;
                  end
               end
            end
            ST_MIX1: begin
               state_ff <= ST_MIX2;
            end
            ST_MIX2: begin
               t_ff     <= T_W'(prod_ff);
               state_ff <= ST_MIX3;
            end
            ST_MIX3: begin
               t_ff     <= t_ff + T_W'(prod_ff) + T_W'(32768);
               state_ff <= ST_MIX4;
            end
            ST_MIX4: begin
               state_ff <= ST_MIX5;
            end
            ST_MIX5: begin
               acc_ff <= acc_ff + ACC_W'(prod_ff);
               if (GCNT_W'(g_ff) + GCNT_W'(1) >= cfg.grain_count) begin
                  state_ff <= ST_FIN;
               end else begin
                  g_ff     <= g_ff + GIDX_W'(1);
                  state_ff <= ST_PH_RD;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  res_valid_ff <= 1'b1;
                  if (acc_top > (ACC_W - 28)'(32767)) begin
                     res_ff <= 16'sh7FFF;
                  end else if (acc_top < -(ACC_W - 28)'(32768)) begin
                     res_ff <= 16'sh8000;
                  end else begin
                     res_ff <= acc_top[SAMPLE_W-1:0];
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign idle       = (state_ff == ST_IDLE);
   assign res_valid  = res_valid_ff;
   assign res_sample = res_ff;

   `GDSR_ASSERT_NEXT(a_fin_emits, (state_ff == ST_FIN) && out_free, res_valid_ff, "tick result not issued")
   `GDSR_ASSERT_IMPLY(a_ph_waddr, ph_we_lo || ph_we_hi, 32'(ph_waddr) < GRAINS, "phase write beyond grains")
   `GDSR_ASSERT_IMPLY(a_rd_in_len, (state_ff == ST_RD1) || (state_ff == ST_RD2), rd_index < cur_len, "sample read beyond length")

endmodule

// ----- rtl/granular_dual_sample_resampler_top.sv -----
// Top level of the granular dual-sample resampler: registers, channels, result register.
// Depends on gdsr_pkg, gdsr_if, gdsr_rem_unit and gdsr_engine.
//
// Two sample memories (low, high) are filled by write transfers and each grain holds one
// fractional phase per memory, set by phase-load transfers. A tick transfer runs every grain
// in use: for each memory it reads two neighbouring words (folded backwards on odd passes
// when ping-pong is on), interpolates linearly, crossfades the two by mix_weight, scales by
// gain, and sums over grains; the sum is rounded and saturated to 16 bits and leaves as one
// result transfer. A tick is paced by the bit-serial remainder unit, which is used four
// times per grain to fold indices and to wrap advanced phases modulo twice the length, and
// by the single read port of each sample memory. A new request is taken once the sequencer
// is idle, even while a result waits in the output register. Register writes are accepted
// at any time but must only be made while the block is idle. Samples are undefined until
// written; phases reset to zero.
module granular_dual_sample_resampler_top #(
   parameter int SAMPLE_DEPTH = gdsr_pkg::SAMPLE_DEPTH_DEF,
   parameter int GRAINS       = gdsr_pkg::GRAINS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   gdsr_req_if.sink                            req_bus,
   gdsr_rsp_if.source                          rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [gdsr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gdsr_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import gdsr_pkg::*;

   logic [LEN_W-1:0]    len_lo_ff;
   logic [LEN_W-1:0]    len_hi_ff;
   logic [STEP_W-1:0]   step_lo_ff;
   logic [STEP_W-1:0]   step_hi_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [GAIN_W-1:0]   gain_ff;
   logic [GIU_W-1:0]    grains_ff;
   logic                ping_pong_ff;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;

   cfg_type     cfg;
   item_type    item;
   rem_req_type rem_req;
   rem_rsp_type rem_rsp;
   logic        eng_idle;
   logic        res_valid;
   logic signed [SAMPLE_W-1:0] res_sample;
   logic        req_transfer;

   // clamp a length into 1..SAMPLE_DEPTH
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      if (len == '0) begin
         return LEN_W'(1);
      end
      if (32'(len) > SAMPLE_DEPTH) begin
         return LEN_W'(SAMPLE_DEPTH);
      end
      return len;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_lo_ff    <= LEN_W'(4096);
         len_hi_ff    <= LEN_W'(4096);
         step_lo_ff   <= STEP_W'(65536);
         step_hi_ff   <= STEP_W'(65536);
         weight_ff    <= '0;
         gain_ff      <= GAIN_W'(4096);
         grains_ff    <= GIU_W'(1);
         ping_pong_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LENGTH_LOW:    len_lo_ff    <= csr_write_data[LEN_W-1:0];
            CSR_LENGTH_HIGH:   len_hi_ff    <= csr_write_data[LEN_W-1:0];
            CSR_STEP_LOW:      step_lo_ff   <= csr_write_data[STEP_W-1:0];
            CSR_STEP_HIGH:     step_hi_ff   <= csr_write_data[STEP_W-1:0];
            CSR_MIX_WEIGHT:    weight_ff    <= csr_write_data[WEIGHT_W-1:0];
            CSR_GAIN:          gain_ff      <= csr_write_data[GAIN_W-1:0];
            CSR_GRAINS_IN_USE: grains_ff    <= csr_write_data[GIU_W-1:0];
            CSR_PING_PONG:     ping_pong_ff <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // effective settings: clamp lengths, weight and grain count
   always_comb begin
      cfg.len_lo      = clamp_len(len_lo_ff);
      cfg.len_hi      = clamp_len(len_hi_ff);
      cfg.step_lo     = step_lo_ff;
      cfg.step_hi     = step_hi_ff;
      cfg.weight      = (weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff;
      cfg.gain        = gain_ff;
      cfg.grain_count = (32'(grains_ff) > GRAINS) ? GCNT_W'(GRAINS) : GCNT_W'(grains_ff);
      cfg.ping_pong   = ping_pong_ff;
   end

   // take a request whenever the sequencer is idle
   assign req_bus.ready = eng_idle;
   assign req_transfer  = req_bus.valid && eng_idle;

   assign item.kind         = req_bus.kind;
   assign item.word_address = req_bus.word_address;
   assign item.sample_value = req_bus.sample_value;
   assign item.grain_index  = req_bus.grain_index;
   assign item.phase_value  = req_bus.phase_value;

   gdsr_rem_unit u_rem (
      .clock (clock),
      .reset (reset),
      .req   (rem_req),
      .rsp   (rem_rsp)
   );

   gdsr_engine #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH),
      .GRAINS       (GRAINS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_transfer),
      .item       (item),
      .cfg        (cfg),
      .out_free   (!rsp_valid_ff),
      .idle       (eng_idle),
      .res_valid  (res_valid),
      .res_sample (res_sample),
      .rem_req    (rem_req),
      .rem_rsp    (rem_rsp)
   );

   // result register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff  <= 1'b1;
         rsp_sample_ff <= res_sample;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.mixed_sample = rsp_sample_ff;

endmodule
